// File: hw/rtl/bounded_circular_deque_unit_defines.svh
// Assertion macros used by the deque top level.
`ifndef BOUNDED_CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BCDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BCDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/bcdq_pkg.sv
// Types and constants of the bounded circular deque.
package bcdq_pkg;

   localparam int MAX_DEPTH  = 1024;
   localparam int IDX_W      = $clog2(MAX_DEPTH);
   localparam int CAP_W      = IDX_W + 1;
   localparam int DATA_W     = 32;
   localparam int MODE_W     = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(MAX_DEPTH);
   localparam logic [CAP_W-1:0]  CAP_MAX   = CAP_W'(MAX_DEPTH);
   localparam logic [CAP_W-1:0]  CAP_MIN   = CAP_W'(1);
   localparam logic [DATA_W-1:0] EMPTY_ITEM = '1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [CAP_W-1:0]  cap_type;
   typedef logic [DATA_W-1:0] data_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_REAR  = 3'd1,
      MODE_DEL_FRONT = 3'd2,
      MODE_DEL_REAR  = 3'd3,
      MODE_STATUS    = 3'd4
   } mode_type;

   // Request state carried from the issue cycle to the result cycle.
   typedef struct packed {
      logic     success;
      logic     is_empty;
      logic     is_full;
      logic     fwd_front;
      logic     fwd_rear;
      data_type wr_data;
   } stage_type;

endpackage

// File: hw/rtl/bcdq_ring_store.sv
// Ring store of the deque: one write port and two registered read ports.
module bcdq_ring_store
   import bcdq_pkg::*;
(
   input  logic     clock,
   input  logic     wr_en,
   input  idx_type  wr_addr,
   input  data_type wr_data,
   input  logic     rd_en,
   input  idx_type  rd_addr_a,
   input  idx_type  rd_addr_b,
   output data_type rd_data_a,
   output data_type rd_data_b
);

   data_type slot_mem [MAX_DEPTH];
   data_type rd_data_a_ff;
   data_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // Old data is returned on a same-address write; the caller forwards.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= slot_mem[rd_addr_a];
         rd_data_b_ff <= slot_mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// File: hw/rtl/bounded_circular_deque_unit.sv
// Top level of the bounded circular deque.
//
//   channel | direction | tdata fields, lowest bit first
//   --------+-----------+------------------------------------------------------
//   req_    | in        | mode[2:0], item_value[34:3], zero pad to 40 bits
//   rsp_    | out       | success[0], front_item[32:1], rear_item[64:33],
//           |           | is_empty[65], is_full[66], zero pad to 72 bits
//   csr_    | in        | capacity[10:0], zero pad to 16 bits
//
// A request updates head, tail and count in the cycle it is accepted and issues
// the front and rear reads of the ring store; read data and request state are
// registered, then the result, and a new request is taken every cycle while
// results drain. A stalled result holds the pending stage and blocks requests.
// Reset clears head, tail and count and sets capacity to 1024; the store is not
// cleared. A capacity write empties the deque.
`include "bounded_circular_deque_unit_defines.svh"

module bounded_circular_deque_unit
   import bcdq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // mode, item_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // success, front, rear, empty, full
   input  logic                  csr_tvalid,
   output logic                  csr_tready,
   input  logic [CSR_DATA_W-1:0] csr_tdata    // capacity
);

   idx_type   head_ff, head_in;
   idx_type   tail_ff, tail_in;
   cap_type   occ_ff, occ_in;
   cap_type   cap_ff, cap_in;
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic      req_fire, csr_fire, s1_move;
   mode_type  req_mode;
   data_type  req_value;
   logic      cur_full, cur_empty, ok;
   idx_type   head_nx, tail_nx;
   cap_type   occ_nx;
   logic      wr_en;
   idx_type   wr_addr;
   idx_type   rd_front_addr, rd_rear_addr;
   data_type  rd_front, rd_rear;
   data_type  front_item, rear_item;
   cap_type   csr_value;

   assign req_mode  = mode_type'(req_tdata[MODE_W-1:0]);
   assign req_value = req_tdata[MODE_W +: DATA_W];
   assign csr_value = csr_tdata[CAP_W-1:0];

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_tready = !s1_valid_ff;
   assign csr_fire   = csr_tvalid && csr_tready;

   assign cur_full  = occ_ff >= cap_ff;
   assign cur_empty = occ_ff == '0;

   // Request decode: new indices, count and store write.
   always_comb begin
      head_nx = head_ff;
      tail_nx = tail_ff;
      occ_nx  = occ_ff;
      wr_en   = 1'b0;
      wr_addr = tail_ff;
      ok      = 1'b0;
      case (req_mode)
         MODE_INS_FRONT: begin
            if (!cur_full) begin
               head_nx = head_ff - idx_type'(1);
               wr_addr = head_nx;
               wr_en   = 1'b1;
               occ_nx  = occ_ff + cap_type'(1);
               ok      = 1'b1;
            end
         end
         MODE_INS_REAR: begin
            if (!cur_full) begin
               tail_nx = tail_ff + idx_type'(1);
               wr_addr = tail_ff;
               wr_en   = 1'b1;
               occ_nx  = occ_ff + cap_type'(1);
               ok      = 1'b1;
            end
         end
         MODE_DEL_FRONT: begin
            if (!cur_empty) begin
               head_nx = head_ff + idx_type'(1);
               occ_nx  = occ_ff - cap_type'(1);
               ok      = 1'b1;
            end
         end
         MODE_DEL_REAR: begin
            if (!cur_empty) begin
               tail_nx = tail_ff - idx_type'(1);
               occ_nx  = occ_ff - cap_type'(1);
               ok      = 1'b1;
            end
         end
         MODE_STATUS: ok = 1'b1;
         default:     ok = 1'b0;
      endcase
   end

   assign rd_front_addr = head_nx;
   assign rd_rear_addr  = tail_nx - idx_type'(1);

   bcdq_ring_store u_store (
      .clock     (clock),
      .wr_en     (req_fire && wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_en     (req_fire),
      .rd_addr_a (rd_front_addr),
      .rd_addr_b (rd_rear_addr),
      .rd_data_a (rd_front),
      .rd_data_b (rd_rear)
   );

   always_comb begin
      s1_in.success   = ok;
      s1_in.is_empty  = occ_nx == '0;
      s1_in.is_full   = occ_nx >= cap_ff;
      s1_in.fwd_front = wr_en && (wr_addr == rd_front_addr);
      s1_in.fwd_rear  = wr_en && (wr_addr == rd_rear_addr);
      s1_in.wr_data   = req_value;
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      cap_in  = cap_ff;
      if (csr_fire) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
         if (csr_value == '0) begin
            cap_in = CAP_MIN;
         end else if (csr_value > CAP_MAX) begin
            cap_in = CAP_MAX;
         end else begin
            cap_in = csr_value;
         end
      end else if (req_fire) begin
         head_in = head_nx;
         tail_in = tail_nx;
         occ_in  = occ_nx;
      end
   end

   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_move);

   // Result: forward the value written in the issue cycle over stale read data.
   always_comb begin
      if (s1_ff.is_empty) begin
         front_item = EMPTY_ITEM;
         rear_item  = EMPTY_ITEM;
      end else begin
         front_item = s1_ff.fwd_front ? s1_ff.wr_data : rd_front;
         rear_item  = s1_ff.fwd_rear  ? s1_ff.wr_data : rd_rear;
      end
   end

   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = s1_move
      ? {5'd0, s1_ff.is_full, s1_ff.is_empty, rear_item, front_item, s1_ff.success}
      : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `BCDQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= cap_ff,
      "occupancy above capacity")
   `BCDQ_ASSERT_NOW(a_ring_span, clock, reset, 1'b1,
      tail_ff == head_ff + occ_ff[IDX_W-1:0], "tail does not match head plus count")
   `BCDQ_ASSERT_NOW(a_stall_block, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp_tready,
      !req_tready, "request taken while the result stage is stalled")
   `BCDQ_ASSERT_NEXT(a_csr_clear, clock, reset, csr_fire, occ_ff == '0,
      "capacity write did not empty the deque")

endmodule

// File: verif/tb_bounded_circular_deque_unit.sv
// Self-checking testbench for the bounded circular deque unit.
`timescale 1ns / 100ps

module tb_bounded_circular_deque_unit;
   import bcdq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // Mode codes outside the defined set; the block must refuse them.
   localparam logic [MODE_W-1:0] MODE_RSVD_LO  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_RSVD_MID = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD_HI  = 3'd7;

   // Same bit order as rsp_tdata, lowest field last.
   typedef struct packed {
      logic     is_full;
      logic     is_empty;
      data_type rear_item;
      data_type front_item;
      logic     success;
   } deque_status;

   typedef struct {
      logic              is_csr;
      cap_type           cap_value;
      logic [MODE_W-1:0] mode;
      data_type          value;
      logic              typed;
      deque_status       want;
   } plan_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // mode, item_value
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // success, front, rear, empty, full
   logic                  csr_tvalid = 1'b0;
   logic                  csr_tready;
   logic [CSR_DATA_W-1:0] csr_tdata = '0;   // capacity

   // Shadow deque state
   data_type ring_mem [MAX_DEPTH];
   idx_type  front_idx = '0;
   idx_type  back_idx = '0;
   int       fill_count = 0;
   int       cap_limit = MAX_DEPTH;

   deque_status awaited_status[$];
   int          fault_count = 0;
   int          cycle_count = 0;
   int          rx_stall = 0;
   logic        rx_steady = 1'b0;
   logic        tx_steady = 1'b0;

   bounded_circular_deque_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bounded_circular_deque_unit regression: fail");
         $finish;
      end
   end

   function automatic int clamp_capacity(input cap_type v);
      if (v == '0) return 1;
      if (v > CAP_MAX) return MAX_DEPTH;
      return int'(v);
   endfunction

   function automatic deque_status apply_request(input logic [MODE_W-1:0] mode,
                                                 input data_type value);
      deque_status s;
      logic        done;
      done = 1'b0;
      case (mode)
         MODE_INS_FRONT: begin
            if (fill_count < cap_limit) begin
               front_idx = idx_type'(front_idx - 1'b1);
               ring_mem[front_idx] = value;
               fill_count++;
               done = 1'b1;
            end
         end
         MODE_INS_REAR: begin
            if (fill_count < cap_limit) begin
               ring_mem[back_idx] = value;
               back_idx = idx_type'(back_idx + 1'b1);
               fill_count++;
               done = 1'b1;
            end
         end
         MODE_DEL_FRONT: begin
            if (fill_count != 0) begin
               front_idx = idx_type'(front_idx + 1'b1);
               fill_count--;
               done = 1'b1;
            end
         end
         MODE_DEL_REAR: begin
            if (fill_count != 0) begin
               back_idx = idx_type'(back_idx - 1'b1);
               fill_count--;
               done = 1'b1;
            end
         end
         MODE_STATUS: done = 1'b1;
         default: done = 1'b0;
      endcase
      s.success    = done;
      s.is_empty   = (fill_count == 0);
      s.is_full    = (fill_count >= cap_limit);
      s.front_item = s.is_empty ? EMPTY_ITEM : ring_mem[front_idx];
      s.rear_item  = s.is_empty ? EMPTY_ITEM : ring_mem[idx_type'(back_idx - 1'b1)];
      return s;
   endfunction

   function automatic plan_row row_step(input logic [MODE_W-1:0] mode, input data_type value);
      plan_row r;
      r = '{is_csr: 1'b0, cap_value: '0, mode: mode, value: value, typed: 1'b0, want: '0};
      return r;
   endfunction

   function automatic plan_row row_typed(input logic [MODE_W-1:0] mode, input data_type value,
                                         input logic ok, input data_type front,
                                         input data_type rear, input logic empty,
                                         input logic full);
      plan_row r;
      r = row_step(mode, value);
      r.typed = 1'b1;
      r.want = '{is_full: full, is_empty: empty, rear_item: rear, front_item: front,
                 success: ok};
      return r;
   endfunction

   function automatic plan_row row_csr(input cap_type cap);
      plan_row r;
      r = row_step(MODE_STATUS, '0);
      r.is_csr = 1'b1;
      r.cap_value = cap;
      return r;
   endfunction

   // Fill bias mostly inserts until the deque is full, then mixes freely.
   function automatic logic [MODE_W-1:0] pick_mode(input logic fill_bias);
      int r;
      if (fill_bias && fill_count < cap_limit) begin
         r = $urandom_range(0, 63);
         if (r == 0) return MODE_STATUS;
         if (r == 1) return MODE_W'($urandom_range(5, 7));
         return r[0] ? MODE_INS_FRONT : MODE_INS_REAR;
      end
      r = $urandom_range(0, 99);
      if (r < 22) return MODE_INS_FRONT;
      if (r < 44) return MODE_INS_REAR;
      if (r < 66) return MODE_DEL_FRONT;
      if (r < 88) return MODE_DEL_REAR;
      if (r < 96) return MODE_STATUS;
      return MODE_W'($urandom_range(5, 7));
   endfunction

   function automatic data_type pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string name, input data_type want, input data_type got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fault_count++;
      end
   endtask

   // Hold each request until taken, then record what the block must answer.
   task automatic send_request(input logic [MODE_W-1:0] mode, input data_type value,
                               input logic typed, input deque_status want);
      int          gap;
      deque_status s;
      if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
      gap = tx_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({value, mode});
      do @(posedge clock); while (!req_tready);
      s = apply_request(mode, value);
      awaited_status.push_back(typed ? want : s);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited_status.size() != 0);
   endtask

   task automatic write_capacity(input cap_type cap);
      drain_results();
      repeat (4) @(posedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= CSR_DATA_W'(cap);
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      cap_limit  = clamp_capacity(cap);
      front_idx  = '0;
      back_idx   = '0;
      fill_count = 0;
   endtask

   always @(posedge clock) begin
      deque_status got;
      deque_status want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(deque_status)-1:0];
            if (awaited_status.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fault_count++;
            end else begin
               want = awaited_status.pop_front();
               check_field("success", 32'(want.success), 32'(got.success));
               check_field("front_item", want.front_item, got.front_item);
               check_field("rear_item", want.rear_item, got.rear_item);
               check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
               check_field("is_full", 32'(want.is_full), 32'(got.is_full));
            end
            if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
            rx_stall = rx_steady ? 0 : $urandom_range(0, 4);
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      plan_row plan[$];
      int      r;
      cap_type cap;

      // Empty deque after reset, extremes, wraparound of the head below zero
      plan.push_back(row_typed(MODE_STATUS, '0, 1'b1, EMPTY_ITEM, EMPTY_ITEM, 1'b1, 1'b0));
      plan.push_back(row_typed(MODE_DEL_FRONT, '0, 1'b0, EMPTY_ITEM, EMPTY_ITEM, 1'b1, 1'b0));
      plan.push_back(row_typed(MODE_DEL_REAR, '1, 1'b0, EMPTY_ITEM, EMPTY_ITEM, 1'b1, 1'b0));
      plan.push_back(row_typed(MODE_INS_REAR, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 1'b0, 1'b0));
      plan.push_back(row_typed(MODE_INS_FRONT, 32'h8000_0000, 1'b1, 32'h8000_0000,
                               32'h7FFF_FFFF, 1'b0, 1'b0));
      plan.push_back(row_step(MODE_INS_REAR, '1));
      plan.push_back(row_step(MODE_INS_FRONT, '0));
      plan.push_back(row_step(MODE_RSVD_LO, 32'h1234_5678));
      plan.push_back(row_step(MODE_RSVD_HI, '1));
      plan.push_back(row_step(MODE_DEL_FRONT, '0));
      plan.push_back(row_step(MODE_DEL_REAR, '0));
      plan.push_back(row_step(MODE_DEL_FRONT, '0));
      plan.push_back(row_step(MODE_DEL_REAR, '0));
      // Capacity zero is taken as one
      plan.push_back(row_csr('0));
      plan.push_back(row_typed(MODE_INS_FRONT, 32'h1234_5678, 1'b1, 32'h1234_5678,
                               32'h1234_5678, 1'b0, 1'b1));
      plan.push_back(row_typed(MODE_INS_REAR, 32'h0000_0005, 1'b0, 32'h1234_5678,
                               32'h1234_5678, 1'b0, 1'b1));
      plan.push_back(row_typed(MODE_RSVD_MID, '0, 1'b0, 32'h1234_5678,
                               32'h1234_5678, 1'b0, 1'b1));
      plan.push_back(row_typed(MODE_DEL_REAR, '0, 1'b1, EMPTY_ITEM, EMPTY_ITEM, 1'b1, 1'b0));
      // Capacity above the store depth saturates
      plan.push_back(row_csr('1));
      plan.push_back(row_step(MODE_INS_FRONT, 32'hA5A5_A5A5));
      plan.push_back(row_csr(cap_type'(2)));
      plan.push_back(row_step(MODE_INS_REAR, 32'hAAAA_AAAA));
      plan.push_back(row_step(MODE_INS_REAR, 32'h5555_5555));
      plan.push_back(row_step(MODE_INS_FRONT, 32'h0F0F_0F0F));
      plan.push_back(row_step(MODE_DEL_FRONT, '0));
      plan.push_back(row_step(MODE_DEL_FRONT, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_capacity(plan[i].cap_value);
         else send_request(plan[i].mode, plan[i].value, plan[i].typed, plan[i].want);
      end

      // Fill the whole store once, then churn at full depth
      write_capacity(CAP_MAX);
      repeat (1100) send_request(pick_mode(1'b1), pick_value(), 1'b0, '0);

      // Mostly small capacities so full and empty edges come often
      repeat (12) begin
         r = $urandom_range(0, 7);
         if (r < 5) cap = cap_type'($urandom_range(1, 8));
         else if (r < 7) cap = cap_type'($urandom_range(9, 64));
         else cap = cap_type'($urandom_range(0, 2047));
         write_capacity(cap);
         repeat (70) begin
            if ($urandom_range(0, 199) == 0) drain_results();
            send_request(pick_mode(1'b0), pick_value(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fault_count == 0) begin
         $display("bounded_circular_deque_unit regression: pass");
      end else begin
         $display("bounded_circular_deque_unit regression: fail");
      end
      $finish;
   end

endmodule
